// ===== rtl/hhfs_pkg.sv =====
// hhfs_pkg: shared types and constants for the heavy-hitter frequency sketch.
// Holds the request and result beat structs and the cell command and status types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package hhfs_pkg;

    localparam int unsigned KEY_IN_W = 32;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned LIMIT_W  = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]   CNT_ONE     = 32'd1;
    localparam logic [CNT_W-1:0]   CNT_ZERO    = 32'd0;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [KEY_IN_W-1:0] item_key;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             key_present;
    } t_res;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_CMP,
        CELL_INC,
        CELL_INS,
        CELL_DEC,
        CELL_SCAN_START,
        CELL_SCAN
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     searching;
    } t_cell_ctl;

    typedef struct packed {
        logic             hit;
        logic             tok_valid;
        logic             tok_free;
        logic [CNT_W-1:0] count;
    } t_cell_sts;

    typedef enum logic [1:0] {
        ST_SCAN_START,
        ST_SCAN,
        ST_IDLE,
        ST_RESOLVE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/hhfs_cell.sv =====
// hhfs_cell: one key/counter cell of the sketch table, with its valid bit,
// its match flag, its insert-slot mark and one stage of the scan token chain.
// Depends on hhfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hhfs_cell #(
    parameter int unsigned KEY_BITS = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  hhfs_pkg::t_cell_ctl    i_ctl,
    input  wire  [KEY_BITS-1:0]    i_key,
    input  wire                    i_tok,
    output logic                   o_tok,
    output hhfs_pkg::t_cell_sts    o_sts
);
    import hhfs_pkg::*;

    logic                r_valid, n_valid;
    logic                r_tok,   n_tok;
    logic                r_slot,  n_slot;
    logic                r_hit,   n_hit;
    logic [KEY_BITS-1:0] r_key,   n_key;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    w_count_inc;

    assign w_count_inc = (r_count == CNT_MAX) ? r_count : r_count + CNT_ONE;

    always_comb begin
        n_valid = r_valid;
        n_tok   = r_tok;
        n_slot  = r_slot;
        n_hit   = r_hit;
        n_key   = r_key;
        n_count = r_count;
        case (i_ctl.op)
            CELL_CMP: begin
                n_hit = r_valid && (r_key == i_key);
            end
            CELL_INC: begin
                if (r_hit) begin
                    n_count = w_count_inc;
                end
            end
            CELL_INS: begin
                if (r_slot) begin
                    n_key   = i_key;
                    n_count = CNT_ONE;
                    n_valid = 1'b1;
                    n_slot  = 1'b0;
                end
            end
            CELL_DEC: begin
                // free the cell when its counter runs out
                if (r_valid) begin
                    if (r_count <= CNT_ONE) begin
                        n_count = CNT_ZERO;
                        n_valid = 1'b0;
                    end else begin
                        n_count = r_count - CNT_ONE;
                    end
                end
            end
            CELL_SCAN_START: begin
                n_tok  = i_tok;
                n_slot = 1'b0;
            end
            CELL_SCAN: begin
                n_tok = i_tok;
                if (r_tok && !r_valid && i_ctl.searching) begin
                    n_slot = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
            r_slot  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
            r_slot  <= n_slot;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
    end

    assign o_tok           = r_tok;
    assign o_sts.hit       = r_hit;
    assign o_sts.tok_valid = r_tok && r_valid;
    assign o_sts.tok_free  = r_tok && !r_valid;
    assign o_sts.count     = r_hit ? ((i_ctl.op == CELL_INC) ? w_count_inc : r_count)
                                   : CNT_ZERO;

endmodule

`default_nettype wire

// ===== rtl/heavy_hitter_frequency_sketch_top.sv =====
// A query or an add of a present key passes the resolve state and then a registered result
// strobe; the next beat may start the cycle the result shows, and busy holds off a new beat
// until then. An insert or a dropped key gives its result the same way, then a table scan
// keeps busy high while a token walks the cell chain.
// Reset: synchronous, active low; all cells clear and a table scan follows with busy high.
// Results cannot be stalled; each strobe lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none

module heavy_hitter_frequency_sketch_top #(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned KEY_BITS    = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // request beat channel
    input  wire                            start,
    output logic                           busy,
    input  hhfs_pkg::t_req                 i_req,
    // result beat channel
    output logic                           o_res_valid,
    output hhfs_pkg::t_res                 o_res,
    // entry_limit write channel
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [hhfs_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import hhfs_pkg::*;

    // occupancy may reach TABLE_DEPTH itself
    localparam int unsigned OCC_W  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SCAN_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CMP_W  = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(TABLE_DEPTH - 1);

    t_state              r_state, n_state;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_type, n_type;
    logic [LIMIT_W-1:0]  r_limit;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic                r_searching, n_searching;
    logic [SCAN_W-1:0]   r_scan_cnt, n_scan_cnt;
    logic                r_res_valid, n_res_valid;
    t_res                r_res, n_res;

    t_cell_ctl           w_ctl;
    logic [KEY_BITS-1:0] w_cell_key;
    logic [TABLE_DEPTH:0]   w_tok;
    t_cell_sts           w_sts [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_hit, w_tok_valid, w_tok_free;
    logic [CNT_W-1:0]    w_cnt_or;
    logic                w_hit_any, w_tok_valid_any, w_tok_free_any;
    logic                w_room;

    // --------------------------------------------------------------------
    // Cell chain: the key and command go to every cell; the scan token
    // hands from each cell to the next one every cycle of a scan.
    // --------------------------------------------------------------------
    assign w_cell_key = (r_state == ST_IDLE) ? KEY_BITS'(i_req.item_key) : r_key;
    assign w_tok[0]   = (r_state == ST_SCAN_START);

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        hhfs_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_key   (w_cell_key),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_sts   (w_sts[g])
        );
        assign w_hit[g]       = w_sts[g].hit;
        assign w_tok_valid[g] = w_sts[g].tok_valid;
        assign w_tok_free[g]  = w_sts[g].tok_free;
    end

    // At most one cell matches, so OR the per-cell counts together.
    always_comb begin
        w_cnt_or = CNT_ZERO;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_cnt_or = w_cnt_or | w_sts[i].count;
        end
    end

    assign w_hit_any       = |w_hit;
    assign w_tok_valid_any = |w_tok_valid;
    assign w_tok_free_any  = |w_tok_free;

    // Insert only while occupancy does not exceed the limit and a free slot was found.
    assign w_room = (CMP_W'(r_occ) <= CMP_W'(r_limit)) && !r_searching;

    // --------------------------------------------------------------------
    // Sequencer
    // --------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SCAN_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        w_ctl.op        = CELL_NOP;
        w_ctl.searching = r_searching;
        n_key           = r_key;
        n_type          = r_type;
        n_occ           = r_occ;
        n_searching     = r_searching;
        n_scan_cnt      = r_scan_cnt;
        n_res_valid     = 1'b0;
        n_res           = r_res;
        case (r_state)
            ST_SCAN_START: begin
                // launch the token into cell 0, clear the old slot mark
                w_ctl.op    = CELL_SCAN_START;
                n_occ       = '0;
                n_searching = 1'b1;
                n_scan_cnt  = '0;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                // count occupied cells and mark the lowest free one
                w_ctl.op = CELL_SCAN;
                if (w_tok_valid_any) begin
                    n_occ = r_occ + OCC_W'(1);
                end
                if (w_tok_free_any) begin
                    n_searching = 1'b0;
                end
                n_scan_cnt = r_scan_cnt + SCAN_W'(1);
                if (r_scan_cnt == SCAN_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    // every cell compares the incoming key in this cycle
                    w_ctl.op = CELL_CMP;
                    n_key    = w_cell_key;
                    n_type   = i_req.req_type;
                    n_state  = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                n_res_valid = 1'b1;
                if ((r_type == REQ_QUERY) || w_hit_any) begin
                    w_ctl.op          = (r_type == REQ_ADD) ? CELL_INC : CELL_NOP;
                    n_res.count       = w_cnt_or;
                    n_res.key_present = w_hit_any;
                    n_state           = ST_IDLE;
                end else if (w_room) begin
                    w_ctl.op          = CELL_INS;
                    n_res.count       = CNT_ONE;
                    n_res.key_present = 1'b1;
                    n_state           = ST_SCAN_START;
                end else begin
                    // table full: decrement everyone and drop the key
                    w_ctl.op          = CELL_DEC;
                    n_res.count       = CNT_ZERO;
                    n_res.key_present = 1'b0;
                    n_state           = ST_SCAN_START;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_searching <= 1'b1;
            r_scan_cnt  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_occ       <= n_occ;
            r_searching <= n_searching;
            r_scan_cnt  <= n_scan_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_type <= n_type;
        r_res  <= n_res;
    end

    // Configuration: take a write beat in any cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/hhfs_checker.sv =====
// hhfs_checker: port-level assertions for the heavy-hitter frequency sketch,
// bound to heavy_hitter_frequency_sketch_top below.
// Depends on hhfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hhfs_checker (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire             i_busy,
    input  wire             i_res_valid,
    input  hhfs_pkg::t_res  i_res
);
    import hhfs_pkg::*;

    // an accepted beat holds off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("busy not raised after accepted request");

    // every accepted beat gives its strobe once its resolve state has passed
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |-> ##2 i_res_valid)
        else $error("result strobe missing two cycles after accept");

    // strobes never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |=> !i_res_valid)
        else $error("result strobe held for more than one cycle");

    // absent key reports zero, present key a nonzero count
    a_count_vs_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> ((i_res.count == CNT_ZERO) != i_res.key_present))
        else $error("count and key_present disagree");

endmodule

bind heavy_hitter_frequency_sketch_top hhfs_checker u_hhfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (start),
    .i_busy      (busy),
    .i_res_valid (o_res_valid),
    .i_res       (o_res)
);

`default_nettype wire

// ===== tb/heavy_hitter_frequency_sketch_checker.sv =====
// Scoreboard for the heavy-hitter frequency sketch: watches request, result and
// limit-write beats, keeps its own cell table and compares every result beat.
// Depends on hhfs_pkg for the beat structs, widths and request codes.
`timescale 1ns / 1ps

module heavy_hitter_frequency_sketch_checker #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire                          i_busy,
    input  hhfs_pkg::t_req               i_req,
    input  wire                          i_res_valid,
    input  hhfs_pkg::t_res               i_res,
    input  wire                          i_cfg_valid,
    input  wire                          i_cfg_ready,
    input  wire  [hhfs_pkg::LIMIT_W-1:0] i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import hhfs_pkg::*;

    logic [KEY_IN_W-1:0] cell_key   [TABLE_DEPTH];
    logic [CNT_W-1:0]    cell_count [TABLE_DEPTH];
    logic                cell_used  [TABLE_DEPTH];
    logic [LIMIT_W-1:0]  entry_limit;
    t_res                expected_counts [$];
    int                  fail_total;

    // Misra-Gries update of the local table for one request beat.
    task automatic sketch_update(input t_req req, output t_res res);
        int i;
        int hit;
        int free_cell;
        int occupied;
        hit       = -1;
        free_cell = -1;
        occupied  = 0;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (cell_used[i] && cell_key[i] == req.item_key && hit < 0)
                hit = i;
        end
        if (req.req_type == REQ_QUERY || hit >= 0) begin
            if (req.req_type == REQ_ADD && cell_count[hit] != CNT_MAX)
                cell_count[hit] = cell_count[hit] + CNT_ONE;
            res.count       = (hit >= 0) ? cell_count[hit] : CNT_ZERO;
            res.key_present = (hit >= 0);
            return;
        end
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (cell_used[i])
                occupied++;
            else if (free_cell < 0)
                free_cell = i;
        end
        if (occupied <= int'(entry_limit) && free_cell >= 0) begin
            cell_key[free_cell]   = req.item_key;
            cell_count[free_cell] = CNT_ONE;
            cell_used[free_cell]  = 1'b1;
            res.count             = CNT_ONE;
            res.key_present       = 1'b1;
            return;
        end
        // Table full for this limit: age every counter and drop the new key.
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (cell_used[i]) begin
                if (cell_count[i] <= CNT_ONE) begin
                    cell_count[i] = CNT_ZERO;
                    cell_used[i]  = 1'b0;
                end else begin
                    cell_count[i] = cell_count[i] - CNT_ONE;
                end
            end
        end
        res.count       = CNT_ZERO;
        res.key_present = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_res predicted;
        t_res oldest;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                cell_used[i] = 1'b0;
            entry_limit = LIMIT_RESET;
            expected_counts.delete();
            fail_total = 0;
        end else begin
            if (i_res_valid) begin
                if (expected_counts.size() == 0) begin
                    $error("result beat with no request outstanding");
                    fail_total++;
                end else begin
                    oldest = expected_counts.pop_front();
                    if (i_res.count !== oldest.count) begin
                        $error("count mismatch: expected %0d, actual %0d",
                               oldest.count, i_res.count);
                        fail_total++;
                    end
                    if (i_res.key_present !== oldest.key_present) begin
                        $error("key_present mismatch: expected %0b, actual %0b",
                               oldest.key_present, i_res.key_present);
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                sketch_update(i_req, predicted);
                expected_counts.push_back(predicted);
            end
            if (i_cfg_valid && i_cfg_ready)
                entry_limit = i_cfg_data;
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_counts.size();
    end

endmodule

// ===== tb/tb_heavy_hitter_frequency_sketch_top.sv =====
// Top of the heavy-hitter frequency sketch testbench: clock, reset, request and
// limit-write stimulus, verdict. Depends on hhfs_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb_heavy_hitter_frequency_sketch_top;
    import hhfs_pkg::*;

    localparam int unsigned TABLE_DEPTH = 64;
    // After the last result, let a trailing table scan finish.
    localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int unsigned POOL_MAX      = 128;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_req               i_req;
    logic               o_res_valid;
    t_res               o_res;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_data;
    int                 fail_count;
    int                 pending;

    logic [KEY_IN_W-1:0] key_pool [POOL_MAX];

    heavy_hitter_frequency_sketch_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (32)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    heavy_hitter_frequency_sketch_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) sketch_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_res_valid  (o_res_valid),
        .i_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Present one request beat after a random idle gap and hold it until taken.
    // With no gap, keep start high so it is never dropped and raised in one step.
    task automatic send_request(input logic kind, input logic [KEY_IN_W-1:0] key);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req.req_type <= kind;
        i_req.item_key <= key;
        do @(posedge i_clk); while (busy);
    endtask

    // Wait for every outstanding result, then let a trailing table scan finish.
    task automatic drain;
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write entry_limit on its own channel; called after reset and after each drain.
    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                  phase;
        int                  n;
        int                  pool_size;
        int                  beats;
        int                  roll;
        int                  pick;
        bit                  skewed;
        logic [LIMIT_W-1:0]  limit;
        logic [LIMIT_W-1:0]  phase_limits [8];

        phase_limits = '{6'd63, 6'd0, 6'd1, 6'd0, 6'd42, 6'd21, 6'd7, 6'd0};
        phase_limits[3] = LIMIT_W'($urandom_range(0, 63));
        phase_limits[7] = LIMIT_W'($urandom_range(0, 63));

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: absent query, insert, increment, all-zero and all-one keys,
        // then a tight limit so a new key ages the table and gets dropped.
        write_limit(6'd2);
        send_request(REQ_QUERY, 32'h0000_0000);
        send_request(REQ_ADD,   32'h0000_0000);
        send_request(REQ_ADD,   32'h0000_0000);
        send_request(REQ_QUERY, 32'h0000_0000);
        send_request(REQ_ADD,   32'hFFFF_FFFF);
        send_request(REQ_ADD,   32'hFFFF_FFFF);
        send_request(REQ_ADD,   32'h1234_5678);
        send_request(REQ_ADD,   32'h8765_4321);
        send_request(REQ_QUERY, 32'h8765_4321);
        send_request(REQ_QUERY, 32'h1234_5678);
        send_request(REQ_ADD,   32'hDEAD_BEEF);
        send_request(REQ_ADD,   32'hCAFE_F00D);
        send_request(REQ_QUERY, 32'h0000_0000);
        drain();

        // Limit zero: only an empty table takes a key.
        write_limit(6'd0);
        send_request(REQ_ADD,   32'h0000_0005);
        send_request(REQ_ADD,   32'h0000_0006);
        send_request(REQ_ADD,   32'h0000_0006);
        send_request(REQ_ADD,   32'h0000_0006);
        send_request(REQ_ADD,   32'h0000_0007);
        send_request(REQ_QUERY, 32'h0000_0006);
        drain();

        // Random phases, one limit each. The first runs at the top limit with a
        // wide, flat key pool so all cells fill and the full-table case is hit.
        for (phase = 0; phase < 8; phase++) begin
            limit = phase_limits[phase];
            write_limit(limit);
            if (phase == 0) begin
                pool_size = 80;
                beats     = 200;
                skewed    = 1'b0;
            end else begin
                pool_size = $urandom_range(4, int'(limit) + 12);
                beats     = 110;
                skewed    = 1'b1;
            end
            for (n = 0; n < pool_size; n++)
                key_pool[n] = $urandom();
            for (n = 0; n < beats; n++) begin
                roll = $urandom_range(0, 99);
                // Favor a few heavy keys so counters climb well past one.
                if (skewed && $urandom_range(0, 1) == 1)
                    pick = $urandom_range(0, (pool_size < 4) ? pool_size - 1 : 3);
                else
                    pick = $urandom_range(0, pool_size - 1);
                if (roll < 10)
                    send_request(logic'($urandom_range(0, 1)), $urandom());
                else if (roll < 25)
                    send_request(REQ_QUERY, key_pool[pick]);
                else
                    send_request(REQ_ADD, key_pool[pick]);
            end
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
